>>> design/maf_pkg.sv
`default_nettype none

package maf_pkg;

  // Field and register widths
  localparam int SAMPLE_W   = 16;
  localparam int MODE_W     = 3;
  localparam int CUTOFF_W   = 16;
  localparam int RES_W      = 8;
  localparam int ALPHA_W    = 16;
  localparam int STATE_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Datapath widths
  localparam int COEF_SHIFT = 3;
  localparam int COEF_W     = CUTOFF_W - COEF_SHIFT;
  localparam int Q_W        = 8;
  localparam int HIGH_W     = 35;
  localparam int MUL_B_W    = ALPHA_W + 1;
  localparam int PROD_W     = 48;
  localparam int FRAC_W     = 8;
  localparam int SUM_W      = PROD_W - FRAC_W + 1;
  localparam int SAT_W      = HIGH_W - FRAC_W;
  localparam int OP_SHIFT   = 15;
  localparam int DC_SHIFT   = 14;

  // Numeric limits
  localparam int SAMPLE_MAX   = 32767;
  localparam int SAMPLE_MIN   = -32768;
  localparam int SVF_MAX_24_8 = 32767 * 256;
  localparam int SVF_MIN_24_8 = -32768 * 256;
  localparam int Q_BASE       = 255;
  localparam int Q_MIN        = 8;
  localparam int DC_SHIFT_MAX = 31;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESONANCE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA       = 3'd3;

  // Filter modes
  localparam logic [MODE_W-1:0] MODE_LOW_PASS  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_HIGH_PASS = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BAND_PASS = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ONE_POLE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DC_BLOCK  = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SVF_HIGH,
    ST_SVF_FH,
    ST_SVF_BAND,
    ST_SVF_FB,
    ST_SVF_FIN,
    ST_OP_MUL,
    ST_OP_FIN,
    ST_DC_FIN,
    ST_PASS_FIN
  } maf_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_MUL_QB,
    OP_HIGH,
    OP_MUL_FH,
    OP_BAND,
    OP_MUL_FB,
    OP_SVF_FIN,
    OP_MUL_DA,
    OP_ONE_POLE_FIN,
    OP_DC_FIN,
    OP_PASS_FIN
  } maf_op_t;

  typedef struct packed {
    logic    capture;
    maf_op_t op;
  } maf_cmd_t;

endpackage

`default_nettype wire

>>> design/maf_ctrl.sv
`default_nettype none

module maf_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  input  wire logic [maf_pkg::MODE_W-1:0]    filter_mode,
  output maf_pkg::maf_cmd_t                  cmd
);

  maf_pkg::maf_state_t state;
  maf_pkg::maf_state_t state_next;
  logic                out_free;
  logic                load_out;

  assign in_stall = (state != maf_pkg::ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= maf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      maf_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (filter_mode <= maf_pkg::MODE_BAND_PASS) begin
            state_next = maf_pkg::ST_SVF_HIGH;
          end else if (filter_mode == maf_pkg::MODE_ONE_POLE) begin
            state_next = maf_pkg::ST_OP_MUL;
          end else if (filter_mode == maf_pkg::MODE_DC_BLOCK) begin
            state_next = maf_pkg::ST_DC_FIN;
          end else begin
            state_next = maf_pkg::ST_PASS_FIN;
          end
        end
      end
      maf_pkg::ST_SVF_HIGH: state_next = maf_pkg::ST_SVF_FH;
      maf_pkg::ST_SVF_FH:   state_next = maf_pkg::ST_SVF_BAND;
      maf_pkg::ST_SVF_BAND: state_next = maf_pkg::ST_SVF_FB;
      maf_pkg::ST_SVF_FB:   state_next = maf_pkg::ST_SVF_FIN;
      maf_pkg::ST_OP_MUL:   state_next = maf_pkg::ST_OP_FIN;
      maf_pkg::ST_SVF_FIN,
      maf_pkg::ST_OP_FIN,
      maf_pkg::ST_DC_FIN,
      maf_pkg::ST_PASS_FIN: begin
        if (out_free) begin
          state_next = maf_pkg::ST_IDLE;
        end
      end
      default: state_next = maf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.capture = 1'b0;
    cmd.op      = maf_pkg::OP_NONE;
    load_out    = 1'b0;
    unique case (state)
      maf_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          // the first SVF product needs only the stored band value
          if (filter_mode <= maf_pkg::MODE_BAND_PASS) begin
            cmd.op = maf_pkg::OP_MUL_QB;
          end
        end
      end
      maf_pkg::ST_SVF_HIGH: cmd.op = maf_pkg::OP_HIGH;
      maf_pkg::ST_SVF_FH:   cmd.op = maf_pkg::OP_MUL_FH;
      maf_pkg::ST_SVF_BAND: cmd.op = maf_pkg::OP_BAND;
      maf_pkg::ST_SVF_FB:   cmd.op = maf_pkg::OP_MUL_FB;
      maf_pkg::ST_OP_MUL:   cmd.op = maf_pkg::OP_MUL_DA;
      maf_pkg::ST_SVF_FIN: begin
        if (out_free) begin
          cmd.op   = maf_pkg::OP_SVF_FIN;
          load_out = 1'b1;
        end
      end
      maf_pkg::ST_OP_FIN: begin
        if (out_free) begin
          cmd.op   = maf_pkg::OP_ONE_POLE_FIN;
          load_out = 1'b1;
        end
      end
      maf_pkg::ST_DC_FIN: begin
        if (out_free) begin
          cmd.op   = maf_pkg::OP_DC_FIN;
          load_out = 1'b1;
        end
      end
      maf_pkg::ST_PASS_FIN: begin
        if (out_free) begin
          cmd.op   = maf_pkg::OP_PASS_FIN;
          load_out = 1'b1;
        end
      end
      default: begin
        cmd.capture = 1'b0;
        cmd.op      = maf_pkg::OP_NONE;
        load_out    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> design/maf_datapath.sv
`default_nettype none

module maf_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire maf_pkg::maf_cmd_t                   cmd,
  input  wire logic [maf_pkg::MODE_W-1:0]          filter_mode,
  input  wire logic [maf_pkg::CUTOFF_W-1:0]        cutoff,
  input  wire logic [maf_pkg::RES_W-1:0]           resonance,
  input  wire logic [maf_pkg::ALPHA_W-1:0]         alpha,
  input  wire logic signed [maf_pkg::SAMPLE_W-1:0] sample_in,
  input  wire logic                                end_of_block,
  output logic signed [maf_pkg::SAMPLE_W-1:0]      sample_out,
  output logic                                     end_of_block_out
);

  localparam int SW = maf_pkg::STATE_W;
  localparam int HW = maf_pkg::HIGH_W;
  localparam int BW = maf_pkg::MUL_B_W;
  localparam int PW = maf_pkg::PROD_W;
  localparam int FW = maf_pkg::FRAC_W;
  localparam int UW = maf_pkg::SUM_W;
  localparam int TW = maf_pkg::SAT_W;
  localparam int XW = maf_pkg::SAMPLE_W;
  localparam int DW = XW + 2;

  localparam logic signed [UW-1:0] SVF_HI = UW'(maf_pkg::SVF_MAX_24_8);
  localparam logic signed [UW-1:0] SVF_LO = UW'(maf_pkg::SVF_MIN_24_8);
  localparam logic signed [TW-1:0] SAT_HI = TW'(maf_pkg::SAMPLE_MAX);
  localparam logic signed [TW-1:0] SAT_LO = TW'(maf_pkg::SAMPLE_MIN);
  localparam logic signed [9:0]    Q_BASE = 10'(maf_pkg::Q_BASE);
  localparam logic signed [9:0]    Q_MIN  = 10'(maf_pkg::Q_MIN);
  localparam logic [maf_pkg::ALPHA_W-1:0] SHIFT_CAP =
    maf_pkg::ALPHA_W'(maf_pkg::DC_SHIFT_MAX);

  function automatic logic [SW-1:0] clamp_state(input logic signed [UW-1:0] v);
    logic signed [UW-1:0] r;
    r = v;
    if (v > SVF_HI) begin
      r = SVF_HI;
    end else if (v < SVF_LO) begin
      r = SVF_LO;
    end
    return r[SW-1:0];
  endfunction

  function automatic logic [XW-1:0] sat16(input logic signed [TW-1:0] v);
    logic signed [TW-1:0] r;
    r = v;
    if (v > SAT_HI) begin
      r = SAT_HI;
    end else if (v < SAT_LO) begin
      r = SAT_LO;
    end
    return r[XW-1:0];
  endfunction

  // Filter state and working registers
  logic [SW-1:0]          first_state;
  logic [SW-1:0]          second_state;
  logic signed [XW-1:0]   x_reg;
  logic                   eob_reg;
  logic signed [HW-1:0]   high_reg;
  logic signed [PW-1:0]   prod;

  logic [maf_pkg::COEF_W-1:0] coef_f;
  logic signed [9:0]          q_raw;
  logic [maf_pkg::Q_W-1:0]    q_val;
  logic signed [HW-1:0]       band_ext;
  logic signed [HW-1:0]       low_ext;
  logic signed [DW-1:0]       op_diff;
  logic signed [HW-1:0]       mul_a;
  logic signed [BW-1:0]       mul_b;
  logic signed [HW+BW-1:0]    mul_full;
  logic signed [PW-FW-1:0]    prod_sh;
  logic signed [HW-1:0]       high_calc;
  logic signed [UW-1:0]       band_sum;
  logic signed [UW-1:0]       low_sum;
  logic [SW-1:0]              band_new;
  logic [SW-1:0]              low_new;
  logic signed [HW-1:0]       svf_sel;
  logic [XW-1:0]              svf_out;
  logic [SW-1:0]              op_acc;
  logic [4:0]                 dc_shift;
  logic signed [SW-1:0]       dc_acc_shr;
  logic [DW-1:0]              dc_diff;
  logic [SW-1:0]              dc_acc;
  logic [XW-1:0]              dc_out;

  assign coef_f = cutoff[maf_pkg::CUTOFF_W-1:maf_pkg::COEF_SHIFT];
  assign q_raw  = Q_BASE - $signed({1'b0, resonance, 1'b0});
  assign q_val  = (q_raw < Q_MIN) ? maf_pkg::Q_W'(Q_MIN) : q_raw[maf_pkg::Q_W-1:0];

  assign band_ext = {{(HW-SW){second_state[SW-1]}}, second_state};
  assign low_ext  = {{(HW-SW){first_state[SW-1]}}, first_state};
  assign op_diff  = {{(DW-XW){x_reg[XW-1]}}, x_reg}
                  - {first_state[SW-1], first_state[SW-1:maf_pkg::OP_SHIFT]};

  // Shared multiplier: operand pair chosen by the current step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      maf_pkg::OP_MUL_QB: begin
        mul_a = band_ext;
        mul_b = {{(BW-maf_pkg::Q_W){1'b0}}, q_val};
      end
      maf_pkg::OP_MUL_FH: begin
        mul_a = high_reg;
        mul_b = {{(BW-maf_pkg::COEF_W){1'b0}}, coef_f};
      end
      maf_pkg::OP_MUL_FB: begin
        mul_a = band_ext;
        mul_b = {{(BW-maf_pkg::COEF_W){1'b0}}, coef_f};
      end
      maf_pkg::OP_MUL_DA: begin
        mul_a = {{(HW-DW){op_diff[DW-1]}}, op_diff};
        mul_b = {1'b0, alpha};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;
  assign prod_sh  = prod[PW-1:FW];

  // SVF update terms
  assign high_calc = {{(HW-XW-FW){x_reg[XW-1]}}, x_reg, {FW{1'b0}}}
                   - low_ext - prod_sh[HW-1:0];
  assign band_sum  = {{(UW-SW){second_state[SW-1]}}, second_state}
                   + {prod_sh[PW-FW-1], prod_sh};
  assign low_sum   = {{(UW-SW){first_state[SW-1]}}, first_state}
                   + {prod_sh[PW-FW-1], prod_sh};
  assign band_new  = clamp_state(band_sum);
  assign low_new   = clamp_state(low_sum);

  always_comb begin
    case (filter_mode)
      maf_pkg::MODE_LOW_PASS:  svf_sel = {{(HW-SW){low_new[SW-1]}}, low_new};
      maf_pkg::MODE_HIGH_PASS: svf_sel = high_reg;
      default:                 svf_sel = band_ext;
    endcase
  end

  assign svf_out = sat16(svf_sel[HW-1:FW]);

  // One-pole accumulator wraps at the state width
  assign op_acc = first_state + prod[SW-1:0];

  // DC blocker
  assign dc_shift   = (alpha > SHIFT_CAP) ? 5'(maf_pkg::DC_SHIFT_MAX) : alpha[4:0];
  assign dc_acc_shr = $signed(first_state) >>> dc_shift;
  assign dc_diff    = {{(DW-XW){x_reg[XW-1]}}, x_reg} - second_state[DW-1:0];
  assign dc_acc     = {dc_diff, {maf_pkg::DC_SHIFT{1'b0}}} + first_state - dc_acc_shr;
  assign dc_out     = sat16({{(TW-(SW-maf_pkg::DC_SHIFT)){dc_acc[SW-1]}},
                             dc_acc[SW-1:maf_pkg::DC_SHIFT]});

  always_ff @(posedge clk) begin
    if (rst) begin
      first_state  <= '0;
      second_state <= '0;
    end else begin
      unique case (cmd.op)
        maf_pkg::OP_BAND:         second_state <= band_new;
        maf_pkg::OP_SVF_FIN:      first_state  <= low_new;
        maf_pkg::OP_ONE_POLE_FIN: first_state  <= op_acc;
        maf_pkg::OP_DC_FIN: begin
          first_state  <= dc_acc;
          second_state <= {{(SW-XW){x_reg[XW-1]}}, x_reg};
        end
        default: begin
          first_state  <= first_state;
          second_state <= second_state;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_reg   <= sample_in;
      eob_reg <= end_of_block;
    end
    if (cmd.op == maf_pkg::OP_HIGH) begin
      high_reg <= high_calc;
    end
    if (cmd.op == maf_pkg::OP_MUL_QB || cmd.op == maf_pkg::OP_MUL_FH ||
        cmd.op == maf_pkg::OP_MUL_FB || cmd.op == maf_pkg::OP_MUL_DA) begin
      prod <= mul_full[PW-1:0];
    end
    unique case (cmd.op)
      maf_pkg::OP_SVF_FIN: begin
        sample_out       <= svf_out;
        end_of_block_out <= eob_reg;
      end
      maf_pkg::OP_ONE_POLE_FIN: begin
        sample_out       <= op_acc[maf_pkg::OP_SHIFT+XW-1:maf_pkg::OP_SHIFT];
        end_of_block_out <= eob_reg;
      end
      maf_pkg::OP_DC_FIN: begin
        sample_out       <= dc_out;
        end_of_block_out <= eob_reg;
      end
      maf_pkg::OP_PASS_FIN: begin
        sample_out       <= x_reg;
        end_of_block_out <= eob_reg;
      end
      default: begin
        sample_out       <= sample_out;
        end_of_block_out <= end_of_block_out;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/multimode_audio_filter.sv
`default_nettype none

// Multimode audio filter: one signed 16-bit sample word in, one filtered word
// out, with the end-of-block mark carried alongside. filter_mode picks a
// Chamberlin state-variable filter (low-pass, high-pass, band-pass; 24.8 fixed
// point, clamped states), a Q15 one-pole low-pass, or a DC blocker; codes 5 to
// 7 pass the sample through. The filter modes share two 32-bit state words
// that are not cleared on a mode change. One item is in flight at a time and
// a single multiplier with a registered product is shared by every multiply
// step: the SVF modes run three dependent products, each followed by an add
// step, the one-pole mode runs one product and an add step, and the DC
// blocker and passthrough run only their final step. A new word is accepted
// the cycle after the result is loaded into the output register, so a new
// word is never taken while one is still in flight, and a result held by
// out_stall also holds off the next word. Write the configuration registers
// only while the block is idle.

module multimode_audio_filter (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // configuration write port
  input  wire logic                                   cfg_wr_en,
  input  wire logic [maf_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [maf_pkg::CFG_DATA_W-1:0]         cfg_data,
  // input channel
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [maf_pkg::SAMPLE_W-1:0]    sample_in,
  input  wire logic                                   end_of_block,
  // output channel
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [maf_pkg::SAMPLE_W-1:0]         sample_out,
  output logic                                        end_of_block_out
);

  // Configuration registers
  logic [maf_pkg::MODE_W-1:0]   filter_mode;
  logic [maf_pkg::CUTOFF_W-1:0] cutoff;
  logic [maf_pkg::RES_W-1:0]    resonance;
  logic [maf_pkg::ALPHA_W-1:0]  alpha;

  maf_pkg::maf_cmd_t cmd;

  // Decode the register index; drop writes past the last register.
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode <= '0;
      cutoff      <= '0;
      resonance   <= '0;
      alpha       <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        maf_pkg::CFG_FILTER_MODE: filter_mode <= cfg_data[maf_pkg::MODE_W-1:0];
        maf_pkg::CFG_CUTOFF:      cutoff      <= cfg_data[maf_pkg::CUTOFF_W-1:0];
        maf_pkg::CFG_RESONANCE:   resonance   <= cfg_data[maf_pkg::RES_W-1:0];
        maf_pkg::CFG_ALPHA:       alpha       <= cfg_data[maf_pkg::ALPHA_W-1:0];
        default: begin
          filter_mode <= filter_mode;
        end
      endcase
    end
  end

  // Sequence the steps of one word and own the output handshake.
  maf_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .filter_mode (filter_mode),
    .cmd         (cmd)
  );

  // Shared multiplier, state words and output register.
  maf_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .filter_mode      (filter_mode),
    .cutoff           (cutoff),
    .resonance        (resonance),
    .alpha            (alpha),
    .sample_in        (sample_in),
    .end_of_block     (end_of_block),
    .sample_out       (sample_out),
    .end_of_block_out (end_of_block_out)
  );

endmodule

`default_nettype wire

>>> tb/sv/multimode_audio_filter_tb.sv
`default_nettype none

module multimode_audio_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import maf_pkg::*;

  // Register indexes past the last register; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam int NUM_PHASES      = 16;
  localparam int WORDS_PER_PHASE = 120;
  localparam int HOLD_PHASE      = 5;
  localparam int LONG_HOLD       = 300;
  localparam int SETTLE_CYCLES   = 20;
  localparam int LIMIT_CYCLES    = 250000;

  // One expected output word.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       eob;
  } out_word_t;

  // One row of the directed plan: either a register write or a sample word,
  // optionally with the output typed in by hand.
  typedef struct {
    bit                          to_reg;
    logic [CFG_IDX_W-1:0]        idx;
    logic [CFG_DATA_W-1:0]       val;
    logic signed [SAMPLE_W-1:0]  smp;
    logic                        eob;
    bit                          known;
    logic signed [SAMPLE_W-1:0]  known_out;
  } plan_row_t;

  // DUT ports; every input starts at a known value.
  logic                        clk;
  logic                        rst          = 1'b1;
  logic                        cfg_wr_en    = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index    = '0;
  logic [CFG_DATA_W-1:0]       cfg_data     = '0;
  logic                        in_valid     = 1'b0;
  logic                        in_stall;
  logic signed [SAMPLE_W-1:0]  sample_in    = '0;
  logic                        end_of_block = 1'b0;
  logic                        out_valid;
  logic                        out_stall    = 1'b0;
  logic signed [SAMPLE_W-1:0]  sample_out;
  logic                        end_of_block_out;

  // Hand-typed output travelling alongside the word on the input side.
  logic                        cur_known     = 1'b0;
  logic signed [SAMPLE_W-1:0]  cur_known_out = '0;

  // Shadow of the configuration registers and of the two shared state words.
  logic [MODE_W-1:0]           mode_q;
  logic [CUTOFF_W-1:0]         cutoff_q;
  logic [RES_W-1:0]            reso_q;
  logic [ALPHA_W-1:0]          alpha_q;
  logic signed [STATE_W-1:0]   acc_word;   // SVF low, one-pole or DC accumulator
  logic signed [STATE_W-1:0]   aux_word;   // SVF band, DC previous input

  out_word_t                   due_samples [$];
  int                          mismatches = 0;
  int                          send_calm  = 0;
  int                          recv_calm  = 0;
  int                          hold_asks  = 0;
  int                          hold_done  = 0;

  multimode_audio_filter u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .sample_in        (sample_in),
    .end_of_block     (end_of_block),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .sample_out       (sample_out),
    .end_of_block_out (end_of_block_out)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Wait before the next word, either side, drawn at random, with
  // occasional calm stretches where the side runs flat out.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v > hi) ? hi : (v < lo) ? lo : v;
  endfunction

  // Filter one sample under the shadow configuration and advance the shadow
  // state. All arithmetic is done in 64 bits so that products are exact;
  // every >>> on a signed operand rounds toward minus infinity.
  function automatic logic signed [SAMPLE_W-1:0] filter_sample(
      logic signed [SAMPLE_W-1:0] smp);
    longint                    x, f, q, lo, bd, hi, acc, d, y;
    int unsigned               sh;
    logic signed [STATE_W-1:0] acc32;
    x = smp;
    y = x;
    if (mode_q <= MODE_BAND_PASS) begin
      // Chamberlin SVF in 24.8; low and band clamp to the 16-bit range
      f = longint'(cutoff_q) >>> COEF_SHIFT;
      q = Q_BASE - 2 * longint'(reso_q);
      if (q < Q_MIN) q = Q_MIN;
      lo = acc_word;
      bd = aux_word;
      hi = x * 256 - lo - ((q * bd) >>> FRAC_W);
      bd = clip(bd + ((f * hi) >>> FRAC_W), SVF_MIN_24_8, SVF_MAX_24_8);
      lo = clip(lo + ((f * bd) >>> FRAC_W), SVF_MIN_24_8, SVF_MAX_24_8);
      acc_word = lo[STATE_W-1:0];
      aux_word = bd[STATE_W-1:0];
      if (mode_q == MODE_LOW_PASS) y = lo;
      else if (mode_q == MODE_HIGH_PASS) y = hi;
      else y = bd;
      y = clip(y >>> FRAC_W, SAMPLE_MIN, SAMPLE_MAX);
    end else if (mode_q == MODE_ONE_POLE) begin
      // Q15 one-pole; accumulator and output both wrap
      acc = acc_word;
      acc = acc + (x - (acc >>> OP_SHIFT)) * longint'(alpha_q);
      acc32 = acc[STATE_W-1:0];
      acc_word = acc32;
      y = acc32 >>> OP_SHIFT;
    end else if (mode_q == MODE_DC_BLOCK) begin
      // DC blocker; pole shift saturates at 31
      sh = (alpha_q > DC_SHIFT_MAX) ? DC_SHIFT_MAX : alpha_q;
      acc = acc_word;
      d = x - longint'(aux_word);
      aux_word = x[STATE_W-1:0];
      acc = d * (longint'(1) << DC_SHIFT) + acc - (acc >>> sh);
      acc32 = acc[STATE_W-1:0];
      acc_word = acc32;
      y = clip(longint'(acc32) >>> DC_SHIFT, SAMPLE_MIN, SAMPLE_MAX);
    end
    // codes 5 to 7 fall through: pass the sample, leave the state alone
    return y[SAMPLE_W-1:0];
  endfunction

  // Scoreboard. Check the output side first so a word accepted on the input
  // at the same edge can never be mistaken for the one coming out.
  always @(posedge clk) begin
    out_word_t want;
    logic signed [SAMPLE_W-1:0] got;
    if (rst) begin
      mode_q   = '0;
      cutoff_q = '0;
      reso_q   = '0;
      alpha_q  = '0;
      acc_word = '0;
      aux_word = '0;
      due_samples.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_samples.size() == 0) begin
          $error("unexpected output word: sample_out %0d end_of_block_out %0b",
                 sample_out, end_of_block_out);
          mismatches++;
        end else begin
          want = due_samples.pop_front();
          if (sample_out !== want.smp) begin
            $error("sample_out: expected %0d, got %0d", want.smp, sample_out);
            mismatches++;
          end
          if (end_of_block_out !== want.eob) begin
            $error("end_of_block_out: expected %0b, got %0b", want.eob,
                   end_of_block_out);
            mismatches++;
          end
        end
      end
      // Track register writes; indexes past the last register are ignored.
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_FILTER_MODE: mode_q   = cfg_data[MODE_W-1:0];
          CFG_CUTOFF:      cutoff_q = cfg_data[CUTOFF_W-1:0];
          CFG_RESONANCE:   reso_q   = cfg_data[RES_W-1:0];
          CFG_ALPHA:       alpha_q  = cfg_data[ALPHA_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        got = filter_sample(sample_in);
        // Hand-typed rows override the prediction; the state still advances.
        if (cur_known) got = cur_known_out;
        due_samples.push_back('{smp: got, eob: end_of_block});
      end
    end
  end

  // Output side: stall a random number of cycles, then take one word. On
  // request hold off for a long stretch so the block backs up its input.
  initial begin : receiver
    int n;
    wait (rst == 1'b0);
    forever begin
      if (hold_asks != hold_done) begin
        n = LONG_HOLD;
        hold_done++;
      end else begin
        n = draw_wait(recv_calm);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog: end the run if the stimulus or the drain hangs.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("multimode_audio_filter_tb failed");
    $finish;
  end

  // Offer one word after a random gap and hold it until accepted.
  task automatic send_word(input logic signed [SAMPLE_W-1:0] smp, input logic eob,
                           input bit known, input logic signed [SAMPLE_W-1:0] kout);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    sample_in     <= smp;
    end_of_block  <= eob;
    cur_known     <= known;
    cur_known_out <= kout;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every outstanding word has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_samples.size() != 0);
  endtask

  // One register write; the strobe drops on the following edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] val);
    return '{to_reg: 1'b1, idx: idx, val: val, smp: '0, eob: 1'b0,
             known: 1'b0, known_out: '0};
  endfunction

  function automatic plan_row_t word_row(logic signed [SAMPLE_W-1:0] smp, logic eob);
    return '{to_reg: 1'b0, idx: '0, val: '0, smp: smp, eob: eob,
             known: 1'b0, known_out: '0};
  endfunction

  function automatic plan_row_t known_row(logic signed [SAMPLE_W-1:0] smp, logic eob,
                                          logic signed [SAMPLE_W-1:0] kout);
    return '{to_reg: 1'b0, idx: '0, val: '0, smp: smp, eob: eob,
             known: 1'b1, known_out: kout};
  endfunction

  initial begin : stimulus
    plan_row_t                  plan [$];
    logic signed [SAMPLE_W-1:0] smp;
    logic [MODE_W-1:0]          mode;
    logic [CUTOFF_W-1:0]        cut;
    logic [RES_W-1:0]           res;
    logic [ALPHA_W-1:0]         alp;

    // Hold reset, then release it for good.
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    plan = '{
      // After reset the cutoff is zero, so the SVF state never moves and
      // the low-pass output is zero.
      known_row(16'sd32767, 1'b0, 16'sd0),
      known_row(-16'sd32768, 1'b1, 16'sd0),
      // High-pass over a frozen zero state is the input itself; upper data
      // bits of the mode write are dropped.
      reg_row(CFG_FILTER_MODE, 16'hFFF8 | 16'(MODE_HIGH_PASS)),
      known_row(-16'sd32768, 1'b0, -16'sd32768),
      known_row(16'sd32767, 1'b1, 16'sd32767),
      // Undefined modes pass the sample through; writes past the last
      // register must not touch the mode.
      reg_row(CFG_FILTER_MODE, 16'h0005),
      known_row(16'sd4660, 1'b1, 16'sd4660),
      reg_row(CFG_SPARE_LO, 16'h0000),
      reg_row(CFG_SPARE_HI, 16'h0000),
      known_row(-16'sd1, 1'b0, -16'sd1),
      reg_row(CFG_FILTER_MODE, 16'h0006),
      known_row(-16'sd21846, 1'b1, -16'sd21846),
      reg_row(CFG_FILTER_MODE, 16'hFFFF),
      known_row(16'sd21845, 1'b0, 16'sd21845),
      // Top cutoff, top resonance (damping floors at its minimum): drive the
      // band-pass and low-pass into the state clamps.
      reg_row(CFG_CUTOFF, 16'hFFFF),
      reg_row(CFG_RESONANCE, 16'hFFFF),
      reg_row(CFG_FILTER_MODE, 16'(MODE_BAND_PASS)),
      word_row(16'sd32767, 1'b0),
      word_row(16'sd32767, 1'b0),
      word_row(-16'sd32768, 1'b0),
      word_row(-16'sd32768, 1'b1),
      reg_row(CFG_FILTER_MODE, 16'(MODE_LOW_PASS)),
      word_row(16'sd32767, 1'b0),
      word_row(16'sd32767, 1'b0),
      // No resonance: full damping on the high-pass.
      reg_row(CFG_RESONANCE, 16'h0000),
      reg_row(CFG_FILTER_MODE, 16'(MODE_HIGH_PASS)),
      word_row(-16'sd32768, 1'b0),
      word_row(16'sd12345, 1'b1),
      // One-pole at full gain, then at zero gain where the output freezes.
      reg_row(CFG_ALPHA, 16'h8000),
      reg_row(CFG_FILTER_MODE, 16'(MODE_ONE_POLE)),
      word_row(16'sd32767, 1'b0),
      word_row(-16'sd32768, 1'b1),
      reg_row(CFG_ALPHA, 16'h0000),
      word_row(16'sd5, 1'b0),
      // DC blocker with zero shift: the output is the clipped difference of
      // two samples once the previous input is known.
      reg_row(CFG_FILTER_MODE, 16'(MODE_DC_BLOCK)),
      word_row(16'sd32767, 1'b0),
      known_row(-16'sd32768, 1'b0, -16'sd32768),
      known_row(16'sd32767, 1'b1, 16'sd32767),
      // Shift far past 31 saturates.
      reg_row(CFG_ALPHA, 16'hFFFF),
      word_row(16'sd1000, 1'b0),
      word_row(-16'sd1000, 1'b1)
    };

    // Walk the plan; drain before every write so the block is idle.
    foreach (plan[i]) begin
      if (plan[i].to_reg) begin
        drain_results();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_word(plan[i].smp, plan[i].eob, plan[i].known, plan[i].known_out);
      end
    end

    // Random phases: new settings each phase, mixed sample content.
    smp = '0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      if (p == NUM_PHASES - 1) mode = MODE_W'($urandom_range(5, 7));
      else mode = MODE_W'(p % 5);
      case ($urandom_range(0, 3))
        0:       cut = '0;
        1:       cut = '1;
        default: cut = CUTOFF_W'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0:       res = '0;
        1:       res = '1;
        default: res = RES_W'($urandom);
      endcase
      if (mode == MODE_ONE_POLE) begin
        case ($urandom_range(0, 4))
          0:       alp = '0;
          1:       alp = 16'h8000;
          2:       alp = '1;
          default: alp = ALPHA_W'($urandom_range(0, 32768));
        endcase
      end else if (mode == MODE_DC_BLOCK) begin
        case ($urandom_range(0, 4))
          0:       alp = '0;
          1:       alp = ALPHA_W'(DC_SHIFT_MAX);
          2:       alp = '1;
          default: alp = ALPHA_W'($urandom_range(0, 40));
        endcase
      end else begin
        alp = ALPHA_W'($urandom);
      end
      write_reg(CFG_FILTER_MODE, {13'($urandom), mode});
      write_reg(CFG_CUTOFF, cut);
      write_reg(CFG_RESONANCE, {8'($urandom), res});
      write_reg(CFG_ALPHA, alp);

      // Ask the receiver for a long hold-off while words keep coming.
      if (p == HOLD_PHASE) hold_asks <= hold_asks + 1;

      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        case ($urandom_range(0, 3))
          0: smp = SAMPLE_W'($urandom);
          1: smp = $urandom_range(0, 1) ? SAMPLE_W'(SAMPLE_MAX) : SAMPLE_W'(SAMPLE_MIN);
          2: smp = SAMPLE_W'(int'($urandom_range(0, 512)) - 256);
          default: ;  // hold the previous sample: a step input
        endcase
        send_word(smp, $urandom_range(0, 7) == 0, 1'b0, '0);
      end
    end

    // Let everything come back, then give the block time to misbehave.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("multimode_audio_filter_tb passed");
    else
      $display("multimode_audio_filter_tb failed");
    $finish;
  end

endmodule

`default_nettype wire

>>> multimode_audio_filter.f
design/maf_pkg.sv
design/maf_ctrl.sv
design/maf_datapath.sv
design/multimode_audio_filter.sv
tb/sv/multimode_audio_filter_tb.sv
